// File: src/hsvfb_pkg.sv
// Shared field widths and constants for the HSV pixel to framebuffer word block.
package hsvfb_pkg;

  localparam int POS_W    = 12;
  localparam int HUE_W    = 16;
  localparam int LEVEL_W  = 9;
  localparam int WIDTH_W  = 13;
  localparam int OFFSET_W = 26;
  localparam int COLOR_W  = 24;

  localparam int          BPP_SHIFT   = 2;
  localparam int          INDEX_W     = OFFSET_W - BPP_SHIFT;
  localparam logic [12:0] WIDTH_RESET = 13'd1920;
  localparam logic [8:0]  Q8_ONE      = 9'd256;
  localparam logic [16:0] FRAC_ONE    = 17'h10000;
  localparam logic [24:0] LEVEL_ONE   = 25'h1000000;

  localparam logic [2:0] SECTOR_RED_RISE   = 3'd0;
  localparam logic [2:0] SECTOR_GREEN_FALL = 3'd1;
  localparam logic [2:0] SECTOR_GREEN_RISE = 3'd2;
  localparam logic [2:0] SECTOR_BLUE_FALL  = 3'd3;
  localparam logic [2:0] SECTOR_BLUE_RISE  = 3'd4;

endpackage

// File: src/hsvfb_if.sv
// Channel interfaces: pixel input, result output and line width configuration.
interface hsvfb_pixel_if;
  logic                           valid;
  logic                           ready;
  logic [hsvfb_pkg::POS_W-1:0]    pos_x;
  logic [hsvfb_pkg::POS_W-1:0]    pos_y;
  logic [hsvfb_pkg::HUE_W-1:0]    hue_angle;
  logic [hsvfb_pkg::LEVEL_W-1:0]  saturation;
  logic [hsvfb_pkg::LEVEL_W-1:0]  brightness;

  modport source(output valid, pos_x, pos_y, hue_angle, saturation, brightness, input ready);
  modport sink(input valid, pos_x, pos_y, hue_angle, saturation, brightness, output ready);
endinterface

interface hsvfb_result_if;
  logic                           valid;
  logic                           ready;
  logic [hsvfb_pkg::OFFSET_W-1:0] byte_offset;
  logic [hsvfb_pkg::COLOR_W-1:0]  color_word;

  modport source(output valid, byte_offset, color_word, input ready);
  modport sink(input valid, byte_offset, color_word, output ready);
endinterface

interface hsvfb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hsvfb_pkg::WIDTH_W-1:0]  line_width_pixels;

  modport source(output valid, line_width_pixels, input ready);
  modport sink(input valid, line_width_pixels, output ready);
endinterface

// File: src/hsv_pixel_to_framebuffer_word.sv
// Top level: HSV pixel to framebuffer byte offset and packed RGB word.
// Throughput: one pixel per cycle; the four stages advance together and
// hold when the output register is full and not taken.
// Reset clears all stage valid bits and loads line width 1920.
// The configuration channel is always ready; the width is sampled at input.
module hsv_pixel_to_framebuffer_word #(
  parameter int MAX_WIDTH = 4096
) (
  input logic            clk,
  input logic            rst,
  hsvfb_pixel_if.sink    pixel,
  hsvfb_result_if.source result,
  hsvfb_cfg_if.sink      cfg
);
  import hsvfb_pkg::*;

  localparam int WBITS = $clog2(MAX_WIDTH + 1);

  function automatic logic [7:0] level_to_byte(input logic [33:0] prod);
    logic [42:0] scaled;
    logic [9:0]  c;
    scaled = {prod, 9'b0} - {9'b0, prod};
    c = scaled[42:33];
    level_to_byte = (c > 10'd255) ? 8'd255 : c[7:0];
  endfunction

  logic               en;
  logic [WIDTH_W-1:0] line_width;

  // stage 1
  logic               s1_valid;
  logic [POS_W-1:0]   s1_x, s1_y;
  logic [LEVEL_W-1:0] s1_s, s1_v;
  logic [2:0]         s1_sector;
  logic [15:0]        s1_f;
  logic [WBITS-1:0]   s1_w;

  // stage 2
  logic               s2_valid;
  logic [POS_W-1:0]   s2_x;
  logic [LEVEL_W-1:0] s2_v;
  logic [2:0]         s2_sector;
  logic [24:0]        s2_n_rise, s2_n_fall, s2_n_low;
  logic [INDEX_W-1:0] s2_wy;

  // stage 3
  logic               s3_valid;
  logic [2:0]         s3_sector;
  logic [33:0]        s3_p_full, s3_p_rise, s3_p_fall, s3_p_low;
  logic [OFFSET_W-1:0] s3_offset;

  // stage 4 (output register)
  logic               s4_valid;
  logic [OFFSET_W-1:0] s4_offset;
  logic [COLOR_W-1:0] s4_color;

  logic [18:0]        hue_x6;
  logic [LEVEL_W-1:0] s_sat, v_sat;
  logic [WBITS-1:0]   w_sat;
  logic [16:0]        m_rise;
  logic [25:0]        sm_rise, sm_fall;
  logic [WBITS+11:0]  wy_full;
  logic [INDEX_W-1:0] pix_index;
  logic [7:0]         c_full, c_rise, c_fall, c_low;
  logic [7:0]         red, green, blue;

  assign en          = !s4_valid || result.ready;
  assign pixel.ready = en;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= WIDTH_RESET;
    end else if (cfg.valid) begin
      line_width <= cfg.line_width_pixels;
    end
  end

  assign hue_x6 = {3'b0, pixel.hue_angle} * 19'd6;
  assign s_sat  = (pixel.saturation > Q8_ONE) ? Q8_ONE : pixel.saturation;
  assign v_sat  = (pixel.brightness > Q8_ONE) ? Q8_ONE : pixel.brightness;
  assign w_sat  = (32'(line_width) > MAX_WIDTH) ? WBITS'(MAX_WIDTH) : WBITS'(line_width);

  assign m_rise  = FRAC_ONE - {1'b0, s1_f};
  assign sm_rise = 26'(s1_s) * 26'(m_rise);
  assign sm_fall = 26'(s1_s) * 26'(s1_f);
  assign wy_full = (WBITS+12)'(s1_w) * (WBITS+12)'(s1_y);

  assign pix_index = s2_wy + INDEX_W'(s2_x);

  assign c_full = level_to_byte(s3_p_full);
  assign c_rise = level_to_byte(s3_p_rise);
  assign c_fall = level_to_byte(s3_p_fall);
  assign c_low  = level_to_byte(s3_p_low);

  always_comb begin
    unique case (s3_sector)
      SECTOR_RED_RISE: begin
        red = c_full; green = c_rise; blue = c_low;
      end
      SECTOR_GREEN_FALL: begin
        red = c_fall; green = c_full; blue = c_low;
      end
      SECTOR_GREEN_RISE: begin
        red = c_low; green = c_full; blue = c_rise;
      end
      SECTOR_BLUE_FALL: begin
        red = c_low; green = c_fall; blue = c_full;
      end
      SECTOR_BLUE_RISE: begin
        red = c_rise; green = c_low; blue = c_full;
      end
      default: begin
        red = c_full; green = c_low; blue = c_fall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pixel.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x      <= pixel.pos_x;
      s1_y      <= pixel.pos_y;
      s1_s      <= s_sat;
      s1_v      <= v_sat;
      s1_sector <= hue_x6[18:16];
      s1_f      <= hue_x6[15:0];
      s1_w      <= w_sat;

      s2_x      <= s1_x;
      s2_v      <= s1_v;
      s2_sector <= s1_sector;
      s2_n_rise <= LEVEL_ONE - sm_rise[24:0];
      s2_n_fall <= LEVEL_ONE - sm_fall[24:0];
      s2_n_low  <= LEVEL_ONE - {s1_s, 16'b0};
      s2_wy     <= INDEX_W'(wy_full);

      s3_sector <= s2_sector;
      s3_p_full <= {1'b0, s2_v, 24'b0};
      s3_p_rise <= 34'(s2_v) * 34'(s2_n_rise);
      s3_p_fall <= 34'(s2_v) * 34'(s2_n_fall);
      s3_p_low  <= 34'(s2_v) * 34'(s2_n_low);
      s3_offset <= {pix_index, {BPP_SHIFT{1'b0}}};

      s4_offset <= s3_offset;
      s4_color  <= {blue, green, red};
    end
  end

  assign result.valid       = s4_valid;
  assign result.byte_offset = s4_offset;
  assign result.color_word  = s4_color;

endmodule

// File: src/hsvfb_checker.sv
// Port-level checker for the HSV pixel to framebuffer word block, with its bind.
module hsvfb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           pixel_ready,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic [hsvfb_pkg::OFFSET_W-1:0] result_byte_offset,
  input logic [hsvfb_pkg::COLOR_W-1:0]  result_color_word
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      $stable(result_byte_offset) && $stable(result_color_word))
    else $error("result payload changed while stalled");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !result_valid || result_ready |-> pixel_ready)
    else $error("pixel channel stalled with a free output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind hsv_pixel_to_framebuffer_word hsvfb_checker u_hsvfb_checker (
  .clk                (clk),
  .rst                (rst),
  .pixel_ready        (pixel.ready),
  .result_valid       (result.valid),
  .result_ready       (result.ready),
  .result_byte_offset (result.byte_offset),
  .result_color_word  (result.color_word)
);

// File: verif/hsv_pixel_to_framebuffer_word_tb.sv
// Self-checking testbench for hsv_pixel_to_framebuffer_word: directed table plus random pixels.
`timescale 1ns / 100ps

module hsv_pixel_to_framebuffer_word_tb;
  import hsvfb_pkg::*;

  localparam int MAX_LINE_WIDTH  = 4096;
  localparam int PIPE_LATENCY    = 4;
  localparam int HOLD_OFF_CYCLES = 48;
  localparam int NUM_PHASES      = 8;
  localparam int PHASE_PIXELS    = 52;
  localparam int TAIL_PIXELS     = 30;
  localparam int NUM_ROWS        = 22;

  typedef struct packed {
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [HUE_W-1:0]   hue_angle;
    logic [LEVEL_W-1:0] saturation;
    logic [LEVEL_W-1:0] brightness;
  } pixel_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic [COLOR_W-1:0]  color_word;
  } fb_word_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  line_width;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [HUE_W-1:0]    hue_angle;
    logic [LEVEL_W-1:0]  saturation;
    logic [LEVEL_W-1:0]  brightness;
    logic                typed;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COLOR_W-1:0]  color_word;
  } stim_row_t;

  stim_row_t directed_rows [NUM_ROWS] = '{
    // width    x        y        hue       sat      val     typed offset        color
    '{13'd1920, 12'd0,    12'd0,    16'h0000, 9'd0,    9'd0,    1'b1, 26'd0,        24'h000000},
    '{13'd1920, 12'd4095, 12'd4095, 16'hFFFF, 9'd256,  9'd256,  1'b1, 26'd31465980, 24'h0000FF},
    '{13'd1920, 12'd0,    12'd1,    16'h0000, 9'd0,    9'd256,  1'b1, 26'd7680,     24'hFFFFFF},
    '{13'd1920, 12'd1,    12'd0,    16'h0000, 9'd256,  9'd256,  1'b1, 26'd4,        24'h0000FF},
    '{13'd1920, 12'd2,    12'd0,    16'h0000, 9'd511,  9'd256,  1'b1, 26'd8,        24'h0000FF},
    '{13'd1920, 12'd3,    12'd0,    16'h0000, 9'd0,    9'd511,  1'b1, 26'd12,       24'hFFFFFF},
    '{13'd1920, 12'd4,    12'd0,    16'h0000, 9'd0,    9'd128,  1'b1, 26'd16,       24'h7F7F7F},
    '{13'd1920, 12'd5,    12'd0,    16'd21846, 9'd256, 9'd256,  1'b1, 26'd20,       24'h00FF00},
    '{13'd1920, 12'd6,    12'd0,    16'd43691, 9'd256, 9'd256,  1'b1, 26'd24,       24'hFF0000},
    '{13'd1920, 12'd7,    12'd9,    16'd5461,  9'd200, 9'd180,  1'b0, 26'd0,        24'h0},
    '{13'd1920, 12'd8,    12'd9,    16'd16384, 9'd200, 9'd180,  1'b0, 26'd0,        24'h0},
    '{13'd1920, 12'd9,    12'd9,    16'd27307, 9'd100, 9'd256,  1'b0, 26'd0,        24'h0},
    '{13'd1920, 12'd10,   12'd9,    16'd38229, 9'd256, 9'd90,   1'b0, 26'd0,        24'h0},
    '{13'd1920, 12'd11,   12'd9,    16'd49152, 9'd300, 9'd400,  1'b0, 26'd0,        24'h0},
    '{13'd1920, 12'd2048, 12'd2048, 16'd60075, 9'd255, 9'd255,  1'b0, 26'd0,        24'h0},
    '{13'd1920, 12'hAAA,  12'h555,  16'hAAAA,  9'h155, 9'h0AA,  1'b0, 26'd0,        24'h0},
    '{13'd0,    12'd4095, 12'd4095, 16'h0000,  9'd0,   9'd0,    1'b1, 26'd16380,    24'h000000},
    '{13'd0,    12'd0,    12'd100,  16'h0000,  9'd0,   9'd256,  1'b1, 26'd0,        24'hFFFFFF},
    '{13'd8191, 12'd4095, 12'd4095, 16'h0000,  9'd0,   9'd256,  1'b1, 26'd67108860, 24'hFFFFFF},
    '{13'd8191, 12'd0,    12'd1,    16'h0000,  9'd0,   9'd0,    1'b1, 26'd16384,    24'h000000},
    '{13'd4096, 12'd0,    12'd2,    16'h0000,  9'd0,   9'd0,    1'b1, 26'd32768,    24'h000000},
    '{13'd1,    12'd7,    12'd3,    16'h5555,  9'h0AA, 9'h155,  1'b0, 26'd0,        24'h0}
  };

  logic clk = 1'b0;
  logic rst;

  hsvfb_pixel_if  pix_if();
  hsvfb_result_if res_if();
  hsvfb_cfg_if    cfg_if();

  hsv_pixel_to_framebuffer_word #(
    .MAX_WIDTH(MAX_LINE_WIDTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  fb_word_t           expected_words[$];
  fb_word_t           front_word;
  logic [WIDTH_W-1:0] line_width_q;
  bit                 idle_enable;
  bit                 hold_off_req;
  int                 pixel_beats;
  int                 result_beats;
  int                 width_writes;
  int                 mismatch_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] level_channel(input logic [8:0] val, input logic [8:0] sat,
                                               input logic [16:0] m);
    logic [63:0] n;
    logic [63:0] c;
    n = 64'(LEVEL_ONE) - 64'(sat) * 64'(m);
    c = (64'd511 * 64'(val) * n) >> 33;
    return (c > 64'd255) ? 8'd255 : c[7:0];
  endfunction

  function automatic fb_word_t predict_word(input logic [WIDTH_W-1:0] width, input pixel_t px);
    logic [8:0]  sat;
    logic [8:0]  val;
    logic [63:0] stride;
    logic [63:0] p;
    logic [15:0] frac;
    logic [7:0]  full, low, rise, fall, r, g, b;
    fb_word_t    word;
    sat    = (px.saturation > Q8_ONE) ? Q8_ONE : px.saturation;
    val    = (px.brightness > Q8_ONE) ? Q8_ONE : px.brightness;
    stride = (width > MAX_LINE_WIDTH) ? 64'(MAX_LINE_WIDTH) : 64'(width);
    p      = 64'(px.hue_angle) * 64'd6;
    frac   = p[15:0];
    full   = level_channel(val, sat, 17'd0);
    low    = level_channel(val, sat, FRAC_ONE);
    rise   = level_channel(val, sat, FRAC_ONE - 17'(frac));
    fall   = level_channel(val, sat, 17'(frac));
    case (p[18:16])
      SECTOR_RED_RISE: begin
        r = full; g = rise; b = low;
      end
      SECTOR_GREEN_FALL: begin
        r = fall; g = full; b = low;
      end
      SECTOR_GREEN_RISE: begin
        r = low; g = full; b = rise;
      end
      SECTOR_BLUE_FALL: begin
        r = low; g = fall; b = full;
      end
      SECTOR_BLUE_RISE: begin
        r = rise; g = low; b = full;
      end
      default: begin
        r = full; g = low; b = fall;
      end
    endcase
    word.byte_offset = OFFSET_W'(((stride * 64'(px.pos_y)) << BPP_SHIFT)
                                 + (64'(px.pos_x) << BPP_SHIFT));
    word.color_word  = {b, g, r};
    return word;
  endfunction

  function automatic logic [POS_W-1:0] random_pos();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] random_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return Q8_ONE;
      2: return LEVEL_W'($urandom_range(257, 511));
      default: return LEVEL_W'($urandom_range(0, 256));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.pos_x = random_pos();
    px.pos_y = random_pos();
    case ($urandom_range(0, 3))
      0: px.hue_angle = HUE_W'((($urandom_range(0, 5) << 16) + $urandom_range(0, 11)) / 6);
      1: px.hue_angle = '1;
      default: px.hue_angle = HUE_W'($urandom);
    endcase
    px.saturation = random_level();
    px.brightness = random_level();
    return px;
  endfunction

  task automatic offer_pixel(input pixel_t px, input fb_word_t want);
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 5)) begin
        @(negedge clk);
        pix_if.valid <= 1'b0;
      end
    end
    @(negedge clk);
    pix_if.valid      <= 1'b1;
    pix_if.pos_x      <= px.pos_x;
    pix_if.pos_y      <= px.pos_y;
    pix_if.hue_angle  <= px.hue_angle;
    pix_if.saturation <= px.saturation;
    pix_if.brightness <= px.brightness;
    do @(posedge clk); while (!pix_if.ready);
    expected_words.push_back(want);
    pixel_beats++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_line_width(input logic [WIDTH_W-1:0] width);
    @(negedge clk);
    cfg_if.valid             <= 1'b1;
    cfg_if.line_width_pixels <= width;
    do @(posedge clk); while (!cfg_if.ready);
    line_width_q = width;
    width_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : pixel_source
    pixel_t             px;
    fb_word_t           want;
    logic [WIDTH_W-1:0] width;
    rst                      = 1'b1;
    pix_if.valid             = 1'b0;
    pix_if.pos_x             = '0;
    pix_if.pos_y             = '0;
    pix_if.hue_angle         = '0;
    pix_if.saturation        = '0;
    pix_if.brightness        = '0;
    cfg_if.valid             = 1'b0;
    cfg_if.line_width_pixels = '0;
    line_width_q             = WIDTH_RESET;
    idle_enable              = 1'b1;
    hold_off_req             = 1'b0;
    pixel_beats              = 0;
    result_beats             = 0;
    width_writes             = 0;
    mismatch_count           = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int row = 0; row < NUM_ROWS; row++) begin
      if (directed_rows[row].line_width != line_width_q) begin
        drain_results();
        write_line_width(directed_rows[row].line_width);
      end
      px = '{directed_rows[row].pos_x, directed_rows[row].pos_y, directed_rows[row].hue_angle,
             directed_rows[row].saturation, directed_rows[row].brightness};
      if (directed_rows[row].typed)
        want = '{directed_rows[row].byte_offset, directed_rows[row].color_word};
      else
        want = predict_word(line_width_q, px);
      offer_pixel(px, want);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: width = 13'd640;
        1: width = 13'd0;
        2: width = 13'd8191;
        3: width = 13'd1;
        4: width = 13'd4096;
        5: width = 13'd4097;
        default: width = WIDTH_W'($urandom_range(0, 8191));
      endcase
      drain_results();
      write_line_width(width);
      idle_enable = (phase != 3);
      if (phase == 2) begin
        idle_enable  = 1'b0;
        hold_off_req = 1'b1;
        repeat (20) begin
          px = random_pixel();
          offer_pixel(px, predict_word(line_width_q, px));
        end
        idle_enable = 1'b1;
      end
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (i == PHASE_PIXELS / 2)
          drain_results();
        px = random_pixel();
        offer_pixel(px, predict_word(line_width_q, px));
      end
    end

    idle_enable = 1'b0;
    repeat (TAIL_PIXELS) begin
      px = random_pixel();
      offer_pixel(px, predict_word(line_width_q, px));
    end
    drain_results();

    $display("Sent %0d pixel beats, checked %0d result beats, %0d line width writes",
             pixel_beats, result_beats, width_writes);
    $display("Covered field extremes, all six hue sectors, level clamping and zero/wide widths");
    if (mismatch_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin : result_sink
    int gap_left;
    int hold_left;
    gap_left     = 0;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        res_if.ready <= 1'b0;
        gap_left--;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        res_if.ready <= 1'b0;
        gap_left = $urandom_range(0, 4);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      result_beats++;
      if (expected_words.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat with none expected, actual offset %0h color %0h",
                 $time, res_if.byte_offset, res_if.color_word);
      end else begin
        front_word = expected_words.pop_front();
        if (res_if.byte_offset !== front_word.byte_offset) begin
          mismatch_count++;
          $display("%0t: byte_offset expected %0h actual %0h",
                   $time, front_word.byte_offset, res_if.byte_offset);
        end
        if (res_if.color_word !== front_word.color_word) begin
          mismatch_count++;
          $display("%0t: color_word expected %0h actual %0h",
                   $time, front_word.color_word, res_if.color_word);
        end
      end
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timeout with %0d results outstanding", expected_words.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
